@@ design/id3_pkg.sv @@
`default_nettype none

package id3_pkg;

  typedef enum logic [2:0] {
    PhMarker,
    PhVerFlags,
    PhTagSize,
    PhFrameHdr,
    PhText,
    PhSkip,
    PhDone
  } phase_e;

  typedef enum logic [1:0] {
    RkText     = 2'd0,
    RkEnd      = 2'd1,
    RkNoTag    = 2'd2,
    RkFinished = 2'd3
  } result_kind_e;

  localparam logic [2:0] FieldTitle   = 3'd0;
  localparam logic [2:0] FieldArtist  = 3'd1;
  localparam logic [2:0] FieldAlbum   = 3'd2;
  localparam logic [2:0] FieldYear    = 3'd3;
  localparam logic [2:0] FieldComment = 3'd4;
  localparam logic [2:0] FieldNone    = 3'd7;

  localparam logic [31:0] IdTit2 = 32'h54495432;
  localparam logic [31:0] IdTpe1 = 32'h54504531;
  localparam logic [31:0] IdTalb = 32'h54414C42;
  localparam logic [31:0] IdTyer = 32'h54594552;
  localparam logic [31:0] IdTdrc = 32'h54445243;
  localparam logic [31:0] IdComm = 32'h434F4D4D;

  localparam logic [29:0] FrameHdrLen   = 30'd10;
  localparam logic [3:0]  MarkerLen     = 4'd3;
  localparam logic [3:0]  VerFlagsLen   = 4'd3;
  localparam logic [3:0]  SizeLen       = 4'd4;
  localparam logic [3:0]  HdrSizeFirst  = 4'd4;
  localparam logic [3:0]  HdrSizeLast   = 4'd7;
  localparam logic [3:0]  HdrLastIdx    = 4'd9;

  typedef struct packed {
    result_kind_e kind;
    logic [2:0]   field;
    logic [7:0]   text;
    logic         last;
  } result_t;

  // Up to two results caused by one input word, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } pair_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  byte_index;
    logic [27:0] tag_length;
    logic [29:0] tag_consumed;
    logic [31:0] frame_tag;
    logic [27:0] payload_left;
    logic [2:0]  current_field;
    logic        text_stopped;
  } parse_state_t;

  localparam parse_state_t ParseReset = '{phase: PhMarker, default: '0};

  function automatic logic [7:0] marker_byte(input logic [1:0] idx);
    logic [7:0] res;
    unique case (idx)
      2'd0:    res = 8'h49;
      2'd1:    res = 8'h44;
      2'd2:    res = 8'h33;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic logic [2:0] classify(input logic [31:0] id);
    logic [2:0] res;
    if (id == IdTit2) begin
      res = FieldTitle;
    end else if (id == IdTpe1) begin
      res = FieldArtist;
    end else if (id == IdTalb) begin
      res = FieldAlbum;
    end else if (id == IdTyer || id == IdTdrc) begin
      res = FieldYear;
    end else if (id == IdComm) begin
      res = FieldComment;
    end else begin
      res = FieldNone;
    end
    return res;
  endfunction

  function automatic result_t make_result(input result_kind_e kind, input logic [2:0] field,
                                          input logic [7:0] text);
    result_t res;
    res.kind  = kind;
    res.field = field;
    res.text  = text;
    res.last  = 1'b0;
    return res;
  endfunction

endpackage

`default_nettype wire

@@ design/id3_parser.sv @@
`default_nettype none

module id3_parser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           start_of_file_i,
  output id3_pkg::pair_t      pair_o
);
  import id3_pkg::*;

  parse_state_t state_q, state_d;

  parse_state_t cur;
  parse_state_t nxt;
  result_t      r0, r1;
  logic [1:0]   n;
  logic [27:0]  pl_dec;
  logic [2:0]   kind;
  logic         stopped;

  always_comb begin
    cur     = start_of_file_i ? ParseReset : state_q;
    nxt     = cur;
    r0      = make_result(RkText, FieldTitle, 8'd0);
    r1      = make_result(RkText, FieldTitle, 8'd0);
    n       = 2'd0;
    pl_dec  = cur.payload_left - 28'd1;
    kind    = classify(cur.frame_tag);
    stopped = cur.text_stopped;

    unique case (cur.phase)
      PhMarker: begin
        if (data_byte_i != marker_byte(cur.byte_index[1:0])) begin
          r0        = make_result(RkNoTag, FieldTitle, 8'd0);
          n         = 2'd1;
          nxt.phase = PhDone;
        end else if (cur.byte_index + 4'd1 >= MarkerLen) begin
          nxt.phase      = PhVerFlags;
          nxt.byte_index = '0;
        end else begin
          nxt.byte_index = cur.byte_index + 4'd1;
        end
      end
      PhVerFlags: begin
        if (cur.byte_index + 4'd1 >= VerFlagsLen) begin
          nxt.phase      = PhTagSize;
          nxt.byte_index = '0;
          nxt.tag_length = '0;
        end else begin
          nxt.byte_index = cur.byte_index + 4'd1;
        end
      end
      PhTagSize: begin
        nxt.tag_length = {cur.tag_length[20:0], data_byte_i[6:0]};
        if (cur.byte_index + 4'd1 >= SizeLen) begin
          nxt.phase        = PhFrameHdr;
          nxt.byte_index   = '0;
          nxt.tag_consumed = '0;
        end else begin
          nxt.byte_index = cur.byte_index + 4'd1;
        end
      end
      PhFrameHdr: begin
        nxt.byte_index = cur.byte_index + 4'd1;
        if (cur.byte_index == 4'd0) begin
          if (cur.tag_consumed >= {2'b00, cur.tag_length} || data_byte_i == 8'd0) begin
            r0             = make_result(RkFinished, FieldTitle, 8'd0);
            n              = 2'd1;
            nxt.phase      = PhDone;
            nxt.byte_index = cur.byte_index;
          end else begin
            nxt.frame_tag = {24'd0, data_byte_i};
          end
        end else if (cur.byte_index < HdrSizeFirst) begin
          nxt.frame_tag = {cur.frame_tag[23:0], data_byte_i};
        end else if (cur.byte_index == HdrSizeFirst) begin
          nxt.payload_left = {21'd0, data_byte_i[6:0]};
        end else if (cur.byte_index <= HdrSizeLast) begin
          nxt.payload_left = {cur.payload_left[20:0], data_byte_i[6:0]};
        end else if (cur.byte_index == HdrLastIdx) begin
          nxt.tag_consumed = cur.tag_consumed + FrameHdrLen + {2'b00, cur.payload_left};
          nxt.byte_index   = '0;
          if (kind != FieldNone) begin
            nxt.current_field = kind;
            nxt.text_stopped  = 1'b0;
            if (cur.payload_left == '0) begin
              r0 = make_result(RkEnd, kind, 8'd0);
              n  = 2'd1;
            end else begin
              nxt.phase = PhText;
            end
          end else if (cur.payload_left != '0) begin
            nxt.phase = PhSkip;
          end
        end
      end
      PhText: begin
        nxt.payload_left = pl_dec;
        if (cur.byte_index == 4'd0) begin
          // The first payload byte is the text encoding and is not passed on.
          nxt.byte_index = 4'd1;
        end else if (!stopped) begin
          n = 2'd1;
          if (data_byte_i != 8'd0) begin
            r0 = make_result(RkText, cur.current_field, data_byte_i);
          end else begin
            r0      = make_result(RkEnd, cur.current_field, 8'd0);
            stopped = 1'b1;
          end
        end
        if (pl_dec == '0) begin
          if (!stopped) begin
            if (n == 2'd0) begin
              r0 = make_result(RkEnd, cur.current_field, 8'd0);
            end else begin
              r1 = make_result(RkEnd, cur.current_field, 8'd0);
            end
            n       = n + 2'd1;
            stopped = 1'b1;
          end
          nxt.phase      = PhFrameHdr;
          nxt.byte_index = '0;
        end
        nxt.text_stopped = stopped;
      end
      PhSkip: begin
        nxt.payload_left = pl_dec;
        if (pl_dec == '0) begin
          nxt.phase      = PhFrameHdr;
          nxt.byte_index = '0;
        end
      end
      PhDone: begin
      end
      default: begin
      end
    endcase

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end else if (n == 2'd2) begin
      r1.last = 1'b1;
    end

    pair_o.count  = n;
    pair_o.first  = r0;
    pair_o.second = r1;

    state_d = accept_i ? nxt : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ParseReset;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ design/id3_result_queue.sv @@
`default_nettype none

module id3_result_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire id3_pkg::pair_t pair_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output id3_pkg::result_t    result_o
);
  import id3_pkg::*;

  pair_t      slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic       sub_q, sub_d;
  logic [1:0] cnt_q, cnt_d;
  pair_t      head;
  logic       pop;
  logic       take;

  always_comb begin
    head        = slot_q[rd_q];
    result_o    = sub_q ? head.second : head.first;
    out_valid_o = (cnt_q != 2'd0);
    full_o      = (cnt_q == 2'd2);
    take        = out_valid_o && out_ready_i;
    // A pair leaves once its final word has been taken.
    pop         = take && result_o.last;

    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    sub_d = sub_q;
    if (pop) begin
      sub_d = 1'b0;
    end else if (take) begin
      sub_d = 1'b1;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      sub_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      sub_q <= sub_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= pair_i;
    end
  end

endmodule

`default_nettype wire

@@ design/id3v2_text_frame_extractor.sv @@
// ID3v2 text frame extractor.
// The input channel (in_valid_i / in_ready_o) carries one file byte per word, with
// start_of_file_i set on the first byte of each file; the first byte after reset is
// also taken as the start of a file. The output channel (out_valid_o / out_ready_i)
// carries result words: text bytes of the title, artist, album, year and comment
// frames, end-of-field marks, a missing-marker error and a tag-finished mark.
// last_result_o flags the final result word caused by a given input byte.
// Each input byte is parsed in the cycle it is accepted, and its results (one or two,
// if any) are written as one entry into a two-entry result queue. The results are
// registered in the queue before they appear on the output.
// Throughput is one input byte per cycle as long as the output keeps up; a byte that
// causes two results holds the output for both words, so the sustained rate is
// bounded by the result count, not by the parser.
// in_ready_o drops only when both queue entries are occupied, so a new byte is still
// taken while one result entry waits on a stalled receiver.
// Reset empties the queue and returns the parser to looking for the "ID3" marker.
`default_nettype none

module id3v2_text_frame_extractor (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       start_of_file_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      result_kind_o,
  output logic [2:0]      field_kind_o,
  output logic [7:0]      text_byte_o,
  output logic            last_result_o
);
  import id3_pkg::*;

  logic    accept;
  logic    full;
  pair_t   pair;
  result_t result;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  id3_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .start_of_file_i(start_of_file_i),
    .pair_o         (pair)
  );

  id3_result_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept && (pair.count != 2'd0)),
    .pair_i     (pair),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .result_o   (result)
  );

  assign result_kind_o = result.kind;
  assign field_kind_o  = result.field;
  assign text_byte_o   = result.text;
  assign last_result_o = result.last;

endmodule

`default_nettype wire

@@ test/id3v2_text_frame_extractor_test.sv @@
`timescale 1ns / 1ps

module id3v2_text_frame_extractor_test;
  import id3_pkg::*;

  localparam int DirectedRows = 25;
  localparam int RandomWords  = 1450;
  localparam int LongHold     = 300;
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 20;
  localparam logic [23:0] MarkerWord = 24'h494433;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } word_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         sof;
    logic         typed;
    logic         one_result;
    result_kind_e kind;
    logic [2:0]   field;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       start_of_file = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] result_kind;
  logic [2:0] field_kind;
  logic [7:0] text_byte;
  logic       last_result;

  // Parser state as the predictor sees it.
  phase_e      cur_phase;
  logic [3:0]  hdr_pos;
  logic [27:0] size_limit;
  logic [29:0] tag_used;
  logic [31:0] frame_code;
  logic [27:0] bytes_left;
  logic [2:0]  cur_field;
  logic        text_done;

  result_t     word_results[$];
  result_t     pending_results[$];
  result_t     want;
  word_t       file_words[$];
  script_row_t script [DirectedRows];

  int  error_count = 0;
  int  parsed_words = 0;
  int  skipped_words = 0;
  int  files_sent = 0;
  int  kind_seen [4] = '{0, 0, 0, 0};
  bit  sender_calm = 1'b0;
  bit  long_hold = 1'b0;

  id3v2_text_frame_extractor dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .start_of_file_i(start_of_file),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_kind_o  (result_kind),
    .field_kind_o   (field_kind),
    .text_byte_o    (text_byte),
    .last_result_o  (last_result)
  );

  always #5 clk = ~clk;

  function automatic void restart_parser();
    cur_phase  = PhMarker;
    hdr_pos    = '0;
    size_limit = '0;
    tag_used   = '0;
    frame_code = '0;
    bytes_left = '0;
    cur_field  = '0;
    text_done  = 1'b0;
  endfunction

  function automatic void note(result_kind_e kind, logic [2:0] field, logic [7:0] text);
    result_t res;
    res.kind  = kind;
    res.field = field;
    res.text  = text;
    res.last  = 1'b0;
    word_results.push_back(res);
  endfunction

  // Works out the results of one accepted word into word_results.
  function automatic void parse_word(input logic [7:0] b, input logic sof);
    logic [2:0] id_field;
    result_t    tail;
    word_results.delete();
    if (sof) restart_parser();
    case (cur_phase)
      PhMarker: begin
        if (b != MarkerWord[8*(2 - hdr_pos) +: 8]) begin
          note(RkNoTag, FieldTitle, 8'h00);
          cur_phase = PhDone;
        end else begin
          hdr_pos++;
          if (hdr_pos >= MarkerLen) begin
            cur_phase = PhVerFlags;
            hdr_pos   = '0;
          end
        end
      end
      PhVerFlags: begin
        hdr_pos++;
        if (hdr_pos >= VerFlagsLen) begin
          cur_phase  = PhTagSize;
          hdr_pos    = '0;
          size_limit = '0;
        end
      end
      PhTagSize: begin
        size_limit = {size_limit[20:0], b[6:0]};
        hdr_pos++;
        if (hdr_pos >= SizeLen) begin
          cur_phase = PhFrameHdr;
          hdr_pos   = '0;
          tag_used  = '0;
        end
      end
      PhFrameHdr: begin
        if (hdr_pos == 4'd0) begin
          if (tag_used >= {2'b00, size_limit} || b == 8'h00) begin
            note(RkFinished, FieldTitle, 8'h00);
            cur_phase = PhDone;
          end else begin
            frame_code = {24'h0, b};
            hdr_pos++;
          end
        end else if (hdr_pos < HdrSizeFirst) begin
          frame_code = {frame_code[23:0], b};
          hdr_pos++;
        end else if (hdr_pos == HdrSizeFirst) begin
          bytes_left = {21'h0, b[6:0]};
          hdr_pos++;
        end else if (hdr_pos <= HdrSizeLast) begin
          bytes_left = {bytes_left[20:0], b[6:0]};
          hdr_pos++;
        end else if (hdr_pos == HdrLastIdx) begin
          case (frame_code)
            IdTit2:         id_field = FieldTitle;
            IdTpe1:         id_field = FieldArtist;
            IdTalb:         id_field = FieldAlbum;
            IdTyer, IdTdrc: id_field = FieldYear;
            IdComm:         id_field = FieldComment;
            default:        id_field = FieldNone;
          endcase
          tag_used = tag_used + FrameHdrLen + {2'b00, bytes_left};
          hdr_pos  = '0;
          if (id_field != FieldNone) begin
            cur_field = id_field;
            text_done = 1'b0;
            if (bytes_left == '0) note(RkEnd, cur_field, 8'h00);
            else cur_phase = PhText;
          end else if (bytes_left != '0) begin
            cur_phase = PhSkip;
          end
        end else begin
          hdr_pos++;
        end
      end
      PhText: begin
        bytes_left = bytes_left - 28'd1;
        // The first payload byte is the encoding byte and is never shown.
        if (hdr_pos == 4'd0) begin
          hdr_pos = 4'd1;
        end else if (!text_done) begin
          if (b != 8'h00) begin
            note(RkText, cur_field, b);
          end else begin
            note(RkEnd, cur_field, 8'h00);
            text_done = 1'b1;
          end
        end
        if (bytes_left == '0) begin
          if (!text_done) begin
            note(RkEnd, cur_field, 8'h00);
            text_done = 1'b1;
          end
          cur_phase = PhFrameHdr;
          hdr_pos   = '0;
        end
      end
      PhSkip: begin
        bytes_left = bytes_left - 28'd1;
        if (bytes_left == '0) begin
          cur_phase = PhFrameHdr;
          hdr_pos   = '0;
        end
      end
      default: ;
    endcase
    if (word_results.size() > 0) begin
      tail = word_results.pop_back();
      tail.last = 1'b1;
      word_results.push_back(tail);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] syncsafe_byte(input logic [6:0] v);
    logic [31:0] r;
    r = $urandom;
    return {r[0], v};
  endfunction

  task automatic put(input logic [7:0] b, input logic sof);
    word_t w;
    w.data = b;
    w.sof  = sof;
    file_words.push_back(w);
  endtask

  // Offers one word, waits for it to be taken and updates the predictor.
  task automatic send_word(input logic [7:0] b, input logic sof, input bit follow_model);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_byte     <= b;
    start_of_file <= sof;
    do @(posedge clk); while (!in_ready);
    if (cur_phase == PhDone && !sof) skipped_words++;
    else parsed_words++;
    parse_word(b, sof);
    if (follow_model) foreach (word_results[i]) pending_results.push_back(word_results[i]);
  endtask

  // A well-formed tag with random frames and a tag size that may or may not match them.
  task automatic build_tag();
    int          nfr;
    int          psz;
    int          total;
    int          r;
    logic [31:0] id;
    logic [27:0] len;
    put(8'h49, 1'b1);
    put(8'h44, 1'b0);
    put(8'h33, 1'b0);
    repeat (3) put(8'($urandom_range(0, 255)), 1'b0);
    repeat (4) put(8'h00, 1'b0);
    total = 0;
    nfr = $urandom_range(0, 5);
    repeat (nfr) begin
      r = $urandom_range(0, 7);
      case (r)
        0: id = IdTit2;
        1: id = IdTpe1;
        2: id = IdTalb;
        3: id = IdTyer;
        4: id = IdTdrc;
        5: id = IdComm;
        6: begin
          id = $urandom;
          if (id[31:24] == 8'h00) id[31:24] = 8'h41;
        end
        default: id = $urandom;
      endcase
      for (int k = 3; k >= 0; k--) put(id[8*k +: 8], 1'b0);
      r = $urandom_range(0, 9);
      if (r == 0) psz = 0;
      else if (r == 1) psz = 1;
      else if (r == 9) psz = $urandom_range(30, 60);
      else psz = $urandom_range(2, 14);
      len = 28'(psz);
      for (int k = 3; k >= 0; k--) put(syncsafe_byte(len[7*k +: 7]), 1'b0);
      repeat (2) put(8'($urandom_range(0, 255)), 1'b0);
      if (psz > 0) begin
        put(8'($urandom_range(0, 255)), 1'b0);
        repeat (psz - 1) begin
          put(($urandom_range(0, 11) == 0) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0);
        end
      end
      total += 10 + psz;
    end
    r = $urandom_range(0, 9);
    if (r < 4) len = 28'(total);
    else if (r < 7) len = 28'(total + $urandom_range(1, 20));
    else if (r == 7) len = 28'($urandom_range(0, total));
    else if (r == 8) len = '0;
    else len = 28'($urandom);
    for (int k = 0; k < 4; k++) file_words[9 - k] = '{syncsafe_byte(len[7*k +: 7]), 1'b0};
    // Padding after the frames starts with zero bytes; otherwise anything may follow.
    if (r >= 4 && r < 7) repeat ($urandom_range(1, 4)) put(8'h00, 1'b0);
    else put(8'($urandom_range(0, 255)), 1'b0);
    repeat ($urandom_range(0, 3)) put(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin : stimulus
    int          r;
    int          pos;
    int          cut;
    logic [7:0]  b;
    logic [31:0] id;
    result_t     typed_res;
    restart_parser();
    script = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, RkNoTag,    FieldTitle},
      '{8'hFF, 1'b0, 1'b1, 1'b0, RkText,     FieldTitle},
      '{8'h49, 1'b1, 1'b1, 1'b0, RkText,     FieldTitle},
      '{8'h58, 1'b0, 1'b1, 1'b1, RkNoTag,    FieldTitle},
      '{8'h49, 1'b1, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h44, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h33, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'hFF, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'hFF, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'hFF, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'hFF, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h54, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h49, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h54, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h32, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'h80, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'hFF, 1'b0, 1'b0, 1'b0, RkText,     FieldTitle},
      '{8'hFF, 1'b0, 1'b1, 1'b1, RkEnd,      FieldTitle},
      '{8'h00, 1'b0, 1'b1, 1'b1, RkFinished, FieldTitle}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: no marker before any start mark, a broken marker, then a tag
    // whose only frame is an empty title, ended by a zero frame id.
    foreach (script[i]) begin
      send_word(script[i].data, script[i].sof, !script[i].typed);
      if (script[i].typed && script[i].one_result) begin
        typed_res = '{script[i].kind, script[i].field, 8'h00, 1'b1};
        pending_results.push_back(typed_res);
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);

    while (parsed_words + skipped_words < RandomWords) begin
      file_words.delete();
      sender_calm = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 72) begin
        build_tag();
      end else if (r < 82) begin
        pos = $urandom_range(0, 2);
        for (int k = 0; k < pos; k++) put(MarkerWord[8*(2 - k) +: 8], k == 0);
        do b = 8'($urandom_range(0, 255)); while (b == MarkerWord[8*(2 - pos) +: 8]);
        put(b, pos == 0);
        repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 91) begin
        // Cut short; the parser is left mid-tag until the next start mark.
        build_tag();
        cut = $urandom_range(1, file_words.size() - 1);
        while (file_words.size() > cut) void'(file_words.pop_back());
      end else if (r < 96) begin
        repeat ($urandom_range(1, 8)) begin
          put(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        // A frame whose size bytes are wholly random, most likely too long to stream out.
        put(8'h49, 1'b1);
        put(8'h44, 1'b0);
        put(8'h33, 1'b0);
        repeat (7) put(8'($urandom_range(0, 255)), 1'b0);
        id = ($urandom_range(0, 1) == 0) ? IdComm : $urandom;
        for (int k = 3; k >= 0; k--) put(id[8*k +: 8], 1'b0);
        repeat (6) put(8'($urandom_range(0, 255)), 1'b0);
        repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)), 1'b0);
      end
      if (files_sent == 3) long_hold = 1'b1;
      foreach (file_words[i]) send_word(file_words[i].data, file_words[i].sof, 1'b1);
      files_sent++;
      if (files_sent % 12 == 0) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d directed words and %0d random files: %0d words parsed, %0d ignored.",
             DirectedRows, files_sent, parsed_words, skipped_words);
    $display("Results checked: %0d text, %0d end of field, %0d no marker, %0d tag finished.",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    if (error_count == 0) begin
      $display("** id3v2_text_frame_extractor: PASSED **");
    end else begin
      $display("** id3v2_text_frame_extractor: FAILED **");
    end
    $finish;
  end

  // Receiver: short and long stalls, calm stretches, and one long hold-off on request.
  initial begin : receiver
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left  = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm_left = $urandom_range(50, 200);
          else if (r < 25) stall_left = $urandom_range(1, 3);
          else if (r < 28) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      kind_seen[result_kind]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d field %0d text %h last %b",
               result_kind, field_kind, text_byte, last_result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
          error_count++;
        end
        if (field_kind !== want.field) begin
          $error("field_kind: expected %0d, got %0d", want.field, field_kind);
          error_count++;
        end
        if (text_byte !== want.text) begin
          $error("text_byte: expected %h, got %h", want.text, text_byte);
          error_count++;
        end
        if (last_result !== want.last) begin
          $error("last_result: expected %b, got %b", want.last, last_result);
          error_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timed out: no word moved for %0d cycles.", StallLimit);
    $display("** id3v2_text_frame_extractor: FAILED **");
    $finish;
  end

endmodule
